@@ hdl/mck_pkg.sv @@
package mck_pkg;

    // widths of the register and the result fields
    localparam int DIT_W = 10;
    localparam int DUR_W = 12;
    localparam int LEN_W = 3;
    localparam int PAT_W = 5;

    localparam logic [DIT_W-1:0] DIT_RESET = 10'd70;

    // character codes
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // patterns packed as {len, bits}; first element in bit 0, 1 means dah
    localparam logic [7:0] LETTER_TAB [26] = '{
        8'h42, 8'h81, 8'h85, 8'h61, 8'h20, 8'h84, 8'h63, 8'h80, 8'h40,
        8'h8E, 8'h65, 8'h82, 8'h43, 8'h41, 8'h67, 8'h86, 8'h8B, 8'h62,
        8'h60, 8'h21, 8'h64, 8'h88, 8'h66, 8'h89, 8'h8D, 8'h83
    };

    localparam logic [7:0] DIGIT_TAB [10] = '{
        8'hBF, 8'hBE, 8'hBC, 8'hB8, 8'hB0, 8'hA0, 8'hA1, 8'hA3, 8'hA7, 8'hAF
    };

    localparam logic [7:0] SLASH_PAT = 8'hA9;

    typedef struct packed {
        logic             ok;
        logic             space;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] bits;
    } pat_t;

    // controller to datapath
    typedef struct packed {
        logic load_char;
        logic load_pat;
        logic emit_on;
        logic emit_off;
        logic emit_space;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ok;
        logic space;
    } status_t;

    // character to element pattern
    function automatic pat_t lookup(input logic [7:0] c);
        pat_t       p;
        logic [7:0] entry;
        logic [7:0] diff;
        p     = '0;
        entry = '0;
        diff  = '0;
        if (c >= CHAR_A && c <= CHAR_Z)
        begin
            diff  = c - CHAR_A;
            entry = LETTER_TAB[diff[4:0]];
            p.ok  = 1'b1;
        end
        else if (c >= CHAR_0 && c <= CHAR_9)
        begin
            diff  = c - CHAR_0;
            entry = DIGIT_TAB[diff[3:0]];
            p.ok  = 1'b1;
        end
        else if (c == CHAR_SLASH)
        begin
            entry = SLASH_PAT;
            p.ok  = 1'b1;
        end
        else if (c == CHAR_SPACE)
        begin
            p.space = 1'b1;
        end
        p.len  = entry[7:5];
        p.bits = entry[4:0];
        return p;
    endfunction

endpackage

@@ hdl/morse_character_keyer.sv @@
// channel  | signals                                   | handshake
// ---------+-------------------------------------------+-------------------------------
// input    | char_code[7:0]                            | start & !busy
// config   | cfg_data[9:0] (dit_ms)                    | cfg_we, always taken
// result   | key_on, duration_ms[11:0], last           | strobe, one cycle, no stall
//
// a character of n elements is latched, looked up in the table, and then gets one
// key-down and one key-up segment per element from the controller state machine;
// space gives a single key-up segment, other codes give no segment at all.
// the result of the final segment appears in the same cycle as busy drops.
// the receiver cannot stall; each segment must be taken in its strobe cycle.
// reset clears the controller and strobe and sets dit_ms to 70.
module morse_character_keyer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [7:0]                   char_code,
    input  logic                         cfg_we,
    input  logic [mck_pkg::DIT_W-1:0]    cfg_data,
    output logic                         strobe,
    output logic                         key_on,
    output logic [mck_pkg::DUR_W-1:0]    duration_ms,
    output logic                         last
);

    mck_pkg::cmd_t    cmd;
    mck_pkg::status_t status;
    logic             last_elem;

    mck_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_elem (last_elem),
        .status    (status),
        .busy      (busy),
        .cmd       (cmd)
    );

    mck_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (char_code),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .last_elem   (last_elem),
        .strobe      (strobe),
        .key_on      (key_on),
        .duration_ms (duration_ms),
        .last        (last)
    );

    // segments of one transaction come back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("segment gap inside a character");

    // a character's final segment is never followed at once by another
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("segment right after final segment");

    // key-down is always followed by key-up
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && key_on |=> strobe && !key_on)
        else $error("key-down not followed by key-up");

    // key-down segment never closes a character
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && key_on |-> !last)
        else $error("final segment with key down");

endmodule

@@ hdl/mck_ctrl.sv @@
module mck_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_elem,
    input  mck_pkg::status_t  status,
    output logic              busy,
    output mck_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOOK  = 3'd1;
    localparam logic [2:0] ST_ON    = 3'd2;
    localparam logic [2:0] ST_OFF   = 3'd3;
    localparam logic [2:0] ST_SPACE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_char = 1'b1;
                    state_next    = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                cmd.load_pat = 1'b1;
                if (status.ok)
                    state_next = ST_ON;
                else if (status.space)
                    state_next = ST_SPACE;
                else
                    state_next = ST_IDLE;
            end
            ST_ON:
            begin
                cmd.emit_on = 1'b1;
                state_next  = ST_OFF;
            end
            ST_OFF:
            begin
                cmd.emit_off = 1'b1;
                state_next   = last_elem ? ST_IDLE : ST_ON;
            end
            ST_SPACE:
            begin
                cmd.emit_space = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ hdl/mck_datapath.sv @@
module mck_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [7:0]                   char_code,
    input  logic                         cfg_we,
    input  logic [mck_pkg::DIT_W-1:0]    cfg_data,
    input  mck_pkg::cmd_t                cmd,
    output mck_pkg::status_t             status,
    output logic                         last_elem,
    output logic                         strobe,
    output logic                         key_on,
    output logic [mck_pkg::DUR_W-1:0]    duration_ms,
    output logic                         last
);

    logic [7:0]                  char_reg;
    logic [mck_pkg::DIT_W-1:0]   dit_reg;
    logic [mck_pkg::DUR_W-1:0]   three_reg;
    logic [mck_pkg::DUR_W-1:0]   three_next;
    logic [mck_pkg::LEN_W-1:0]   cnt_reg;
    logic [mck_pkg::PAT_W-1:0]   bits_reg;
    logic                        strobe_reg;
    logic                        key_on_reg;
    logic [mck_pkg::DUR_W-1:0]   dur_reg;
    logic                        last_reg;
    logic [mck_pkg::DUR_W-1:0]   one_dur;
    mck_pkg::pat_t               pat;

    // table lookup on the held character
    assign pat          = mck_pkg::lookup(char_reg);
    assign status.ok    = pat.ok;
    assign status.space = pat.space;
    assign last_elem    = (cnt_reg == mck_pkg::LEN_W'(1));

    assign one_dur    = mck_pkg::DUR_W'(dit_reg);
    assign three_next = mck_pkg::DUR_W'(cfg_data) + mck_pkg::DUR_W'({cfg_data, 1'b0});

    // dit register and its triple
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dit_reg   <= mck_pkg::DIT_RESET;
            three_reg <= mck_pkg::DUR_W'(mck_pkg::DIT_RESET) * mck_pkg::DUR_W'(3);
        end
        else if (cfg_we)
        begin
            dit_reg   <= cfg_data;
            three_reg <= three_next;
        end
    end

    // character and element shift register
    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
            char_reg <= char_code;
        if (cmd.load_pat)
        begin
            cnt_reg  <= pat.len;
            bits_reg <= pat.bits;
        end
        else if (cmd.emit_off)
        begin
            cnt_reg  <= cnt_reg - mck_pkg::LEN_W'(1);
            bits_reg <= bits_reg >> 1;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.emit_on | cmd.emit_off | cmd.emit_space;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_on)
        begin
            key_on_reg <= 1'b1;
            dur_reg    <= bits_reg[0] ? three_reg : one_dur;
            last_reg   <= 1'b0;
        end
        else if (cmd.emit_off)
        begin
            key_on_reg <= 1'b0;
            dur_reg    <= last_elem ? three_reg : one_dur;
            last_reg   <= last_elem;
        end
        else if (cmd.emit_space)
        begin
            key_on_reg <= 1'b0;
            dur_reg    <= three_reg;
            last_reg   <= 1'b1;
        end
    end

    assign strobe      = strobe_reg;
    assign key_on      = key_on_reg;
    assign duration_ms = dur_reg;
    assign last        = last_reg;

endmodule
